FILE: hw/rtl/ftsm_pkg.sv
`default_nettype none
package ftsm_pkg;
  localparam int unsigned WindowDepthDef = 120;
  localparam logic [19:0] UsPerSec = 20'd1000000;
  localparam logic [19:0] FpsMax = 20'd1000000;
  localparam logic [19:0] TargetRst = 20'd16667;
  localparam int unsigned SleepMinUs = 500;

  typedef enum logic [1:0] {
    RegEnable = 2'd0,
    RegTarget = 2'd1,
    RegMode   = 2'd2
  } reg_idx_e;

  localparam logic [1:0] ModeImmediate = 2'd1;
  localparam logic [1:0] ModeHalfRate  = 2'd2;

  // decoded frame handed from front to back
  typedef struct packed {
    logic [31:0] frame_us;
    logic [6:0]  pct;
    logic [20:0] sleep_us;
  } job_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ftsm_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, 64 by 64
module ftsm_div
  import ftsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ftsm_front.sv
`default_nettype none
// takes frame words, computes frame time and sleep, pushes into a two-entry queue
module ftsm_front
  import ftsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic        enable_i,
  input  wire logic [19:0] target_i,
  input  wire logic [1:0]  mode_i,
  output logic             job_valid_o,
  input  wire logic        job_pop_i,
  output job_t             job_o
);
  job_t        fifo_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic [31:0] frame;
  logic [21:0] period;
  logic [32:0] remaining;
  logic [34:0] rem3;
  logic [20:0] sleep;
  logic        push;
  job_t        job;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready && enable_i;

  always_comb begin
    frame  = s_axis_tdata[63:32] - s_axis_tdata[31:0];
    period = (mode_i == ModeHalfRate) ? {1'b0, target_i, 1'b0} : {2'b00, target_i};
    remaining = {11'd0, period} - {1'b0, frame};
    rem3  = {remaining[32], remaining[32], remaining} + {remaining[32], remaining, 1'b0};
    sleep = '0;
    if (mode_i != ModeImmediate && !remaining[32] &&
        remaining[31:0] > 32'(SleepMinUs))
      sleep = rem3[22:2];
    job.frame_us = frame;
    job.pct      = (s_axis_tdata[70:64] > 7'd100) ? 7'd100 : s_axis_tdata[70:64];
    job.sleep_us = sleep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (job_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= job;
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = fifo_q[rd_q];
endmodule
`default_nettype wire

FILE: hw/rtl/ftsm_back.sv
`default_nettype none
// updates totals and window, runs the divisions and the rank scan
module ftsm_back
  import ftsm_pkg::*;
#(
  parameter int unsigned WindowDepth = WindowDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         job_valid_i,
  output logic              job_pop_o,
  input  job_t              job_i,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [188:0]      m_axis_tdata
);
  localparam int unsigned Aw = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned Cw = $clog2(WindowDepth + 1);
  // ceil(2^24 / 100), gives floor(x / 100) exactly for x below 2^17
  localparam logic [17:0] RankRecip = 18'd167773;

  typedef enum logic [3:0] {
    StIdle, StUpd, StFpsDiv, StAvgGo, StAvgDiv, StAfpsDiv, StRank, StLoadV, StGetV,
    StInner, StCheck, StOut
  } state_e;

  state_e        state_q;
  logic [31:0]   mem_q [WindowDepth];
  logic [Cw-1:0] fill_q;
  logic [Aw-1:0] ptr_q, i_q, j_q, rank_q;
  logic [31:0]   frames_q, sec_frames_q, sec_frames_inc;
  logic [63:0]   time_q;
  logic [32:0]   sec_time_q;
  logic [19:0]   fps_q, afps_q;
  logic [31:0]   avg_q, v_q, rd_q, pval_q, rdv;
  logic          rdok_q, rdlast_q;
  logic [Cw-1:0] below_q, upto_q;
  logic [16:0]   rank_prod_q;
  logic [34:0]   rank_mul;
  job_t          job_q;
  logic          dstart;
  logic [63:0]   dnum, dden, dquo;
  logic          ddone;
  logic [51:0]   sec_scaled, frames_scaled;
  logic [188:0]  out_q;
  logic          ov_q, out_load, sec_roll, hit;
  logic [64:0]   tsum;
  logic [32:0]   ssum;

  ftsm_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  assign tsum = {1'b0, time_q} + {33'd0, job_q.frame_us};
  assign ssum = sec_time_q + {1'b0, job_q.frame_us};
  assign sec_roll = (ssum >= {13'd0, UsPerSec});
  assign sec_frames_inc = (sec_frames_q != '1) ? sec_frames_q + 32'd1 : sec_frames_q;
  assign sec_scaled = {20'd0, sec_frames_inc} * {32'd0, UsPerSec};
  assign frames_scaled = {20'd0, frames_q} * {32'd0, UsPerSec};
  assign rank_mul = {18'd0, rank_prod_q} * {17'd0, RankRecip};
  assign job_pop_o = (state_q == StIdle) && job_valid_i;
  // unfilled slots read as zero
  assign rdv = rdok_q ? rd_q : 32'd0;
  assign hit = (below_q <= Cw'(rank_q)) && (Cw'(rank_q) < upto_q);
  assign out_load = (state_q == StOut) && (!ov_q || m_axis_tready);

  always_comb begin
    dstart = 1'b0;
    dnum = '0;
    dden = 64'd1;
    if (state_q == StUpd && sec_roll) begin
      dstart = 1'b1;
      dnum = {12'd0, sec_scaled};
      dden = {31'd0, ssum};
    end else if (state_q == StAvgGo) begin
      dstart = 1'b1;
      dnum = time_q;
      dden = {32'd0, frames_q};
    end else if (state_q == StAvgDiv && ddone && time_q != '0) begin
      dstart = 1'b1;
      dnum = {12'd0, frames_scaled};
      dden = time_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[j_q];
    if (state_q == StUpd) mem_q[ptr_q] <= job_q.frame_us;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      job_q <= '0;
      fill_q <= '0; ptr_q <= '0;
      frames_q <= '0; time_q <= '0;
      sec_frames_q <= '0; sec_time_q <= '0;
      fps_q <= '0; afps_q <= '0; avg_q <= '0;
      rank_prod_q <= '0; rank_q <= '0;
      i_q <= '0; j_q <= '0;
      v_q <= '0; below_q <= '0; upto_q <= '0; pval_q <= '0;
      rdok_q <= 1'b0; rdlast_q <= 1'b0;
      out_q <= '0;
      ov_q <= 1'b0;
    end else begin
      rdok_q <= (fill_q > Cw'(j_q));
      rdlast_q <= (j_q == Aw'(WindowDepth - 1));
      if (out_load) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (out_load) begin
        out_q <= {job_q.sleep_us, pval_q, afps_q, fps_q, frames_q, avg_q, job_q.frame_us};
      end
      unique case (state_q)
        StIdle: if (job_valid_i) begin
          job_q <= job_i;
          state_q <= StUpd;
        end
        StUpd: begin
          time_q <= tsum[64] ? '1 : tsum[63:0];
          if (frames_q != '1) frames_q <= frames_q + 32'd1;
          ptr_q <= (ptr_q == Aw'(WindowDepth - 1)) ? '0 : ptr_q + Aw'(1);
          if (fill_q != Cw'(WindowDepth)) fill_q <= fill_q + Cw'(1);
          rank_prod_q <= 17'(job_q.pct) * 17'(WindowDepth - 1);
          if (sec_roll) begin
            sec_time_q <= '0;
            sec_frames_q <= '0;
            state_q <= StFpsDiv;
          end else begin
            sec_time_q <= ssum;
            sec_frames_q <= sec_frames_inc;
            state_q <= StAvgGo;
          end
        end
        StFpsDiv: if (ddone) begin
          fps_q <= (dquo > 64'(FpsMax)) ? FpsMax : dquo[19:0];
          state_q <= StAvgGo;
        end
        StAvgGo: state_q <= StAvgDiv;
        StAvgDiv: if (ddone) begin
          avg_q <= (dquo > 64'hFFFF_FFFF) ? '1 : dquo[31:0];
          if (time_q == '0) begin
            afps_q <= FpsMax;
            state_q <= StRank;
          end else begin
            state_q <= StAfpsDiv;
          end
        end
        StAfpsDiv: if (ddone) begin
          afps_q <= (dquo > 64'(FpsMax)) ? FpsMax : dquo[19:0];
          state_q <= StRank;
        end
        StRank: begin
          rank_q <= rank_mul[24 +: Aw];
          i_q <= '0;
          j_q <= '0;
          state_q <= StLoadV;
        end
        StLoadV: begin
          // candidate i is read here, the sweep restarts at slot zero
          j_q <= '0;
          state_q <= StGetV;
        end
        StGetV: begin
          v_q <= rdv;
          below_q <= '0;
          upto_q <= '0;
          j_q <= Aw'(1);
          state_q <= StInner;
        end
        StInner: begin
          // rd holds the slot that j addressed in the previous cycle
          below_q <= below_q + Cw'(rdv < v_q);
          upto_q <= upto_q + Cw'(rdv <= v_q);
          if (rdlast_q) state_q <= StCheck;
          else if (j_q != Aw'(WindowDepth - 1)) j_q <= j_q + Aw'(1);
        end
        StCheck: begin
          if (hit || i_q == Aw'(WindowDepth - 1)) begin
            pval_q <= hit ? v_q : 32'd0;
            state_q <= StOut;
          end else begin
            i_q <= i_q + Aw'(1);
            j_q <= i_q + Aw'(1);
            state_q <= StLoadV;
          end
        end
        StOut: if (!ov_q || m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

FILE: hw/rtl/frame_time_statistics_monitor.sv
`default_nettype none
// Frame time statistics monitor. Each accepted word carries a frame's start and end
// times and a percentile; one result word follows per frame while enabled. The time
// a frame takes is set by the serial divider, used one to three times, and by the
// rank scan, which sweeps the whole window once per candidate entry. A two-word
// queue and one output register let the input and result sides stall on their own.
module frame_time_statistics_monitor
  import ftsm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WindowDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,  // start_us, end_us, percentile
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,  // frame_us, avg_frame_us, frames_seen,
                                           // current_fps, average_fps, pct_frame_us, sleep_us
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  logic        enable_q;
  logic [19:0] target_q;
  logic [1:0]  mode_q;
  logic        jv, jp;
  job_t        job;
  logic [188:0] od;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      target_q <= TargetRst;
      mode_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEnable: enable_q <= cfg_data_i[0];
        RegTarget: target_q <= cfg_data_i[19:0];
        RegMode:   mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ftsm_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .enable_i(enable_q), .target_i(target_q), .mode_i(mode_q),
    .job_valid_o(jv), .job_pop_i(jp), .job_o(job)
  );

  ftsm_back #(.WindowDepth(WINDOW_DEPTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_pop_o(jp), .job_i(job),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata(od)
  );

  assign m_axis_tdata = {3'd0, od};
endmodule
`default_nettype wire

FILE: tb/sv/frame_time_statistics_monitor_tb.sv
`timescale 1ns / 1ps
module frame_time_statistics_monitor_tb;
  import ftsm_pkg::*;

  localparam int unsigned Depth = WindowDepthDef;
  // worst frame: rank scan plus divider passes, with margin
  localparam int unsigned FrameCycles = 2 * Depth * Depth + 400;

  typedef struct {
    logic [31:0] frame_us;
    logic [31:0] avg_frame_us;
    logic [31:0] frames_seen;
    logic [19:0] current_fps;
    logic [19:0] average_fps;
    logic [31:0] pct_frame_us;
    logic [20:0] sleep_us;
  } frame_report_t;

  class frame_stats_board;
    bit              enable = 1'b1;
    bit [19:0]       target_us = TargetRst;
    bit [1:0]        mode = 2'd0;
    bit [31:0]       window[Depth];
    int unsigned     oldest = 0;
    bit [31:0]       frame_count = 0;
    longint unsigned time_sum = 0;
    bit [31:0]       sec_frames = 0;
    longint unsigned sec_time = 0;
    bit [19:0]       fps_latch = 0;
    frame_report_t   expected_reports[$];
    int              errors = 0;

    function new();
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [31:0] data);
      case (idx)
        RegEnable: enable = data[0];
        RegTarget: target_us = data[19:0];
        RegMode:   mode = data[1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(bit [31:0] start_us, bit [31:0] end_us, bit [6:0] pct);
      frame_report_t   r;
      bit [31:0]       sorted[$];
      bit [31:0]       frame;
      longint unsigned q;
      longint          period;
      longint          remaining;
      int unsigned     p;
      if (!enable) return;
      frame = end_us - start_us;
      if (time_sum > 64'hFFFF_FFFF_FFFF_FFFF - frame) time_sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else time_sum += frame;
      if (frame_count != 32'hFFFF_FFFF) frame_count++;
      window[oldest] = frame;
      oldest = (oldest + 1 >= Depth) ? 0 : oldest + 1;
      if (sec_frames != 32'hFFFF_FFFF) sec_frames++;
      sec_time += frame;
      if (sec_time >= 1000000) begin
        q = (longint'(sec_frames) * 1000000) / sec_time;
        fps_latch = (q > 1000000) ? 20'd1000000 : q[19:0];
        sec_frames = 0;
        sec_time = 0;
      end
      r.frame_us = frame;
      q = time_sum / frame_count;
      r.avg_frame_us = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      r.frames_seen = frame_count;
      r.current_fps = fps_latch;
      if (time_sum == 0) r.average_fps = 20'd1000000;
      else begin
        q = (longint'(frame_count) * 1000000) / time_sum;
        r.average_fps = (q > 1000000) ? 20'd1000000 : q[19:0];
      end
      p = (pct > 100) ? 100 : pct;
      foreach (window[i]) sorted.insert(i, window[i]);
      sorted.sort();
      r.pct_frame_us = sorted[(p * (Depth - 1)) / 100];
      r.sleep_us = '0;
      if (mode != ModeImmediate) begin
        period = target_us;
        if (mode == ModeHalfRate) period *= 2;
        remaining = period - longint'(frame);
        if (remaining > longint'(SleepMinUs)) r.sleep_us = 21'((remaining * 3) / 4);
      end
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    function void check_report(logic [191:0] d);
      frame_report_t e;
      if (expected_reports.size() == 0) begin
        $error("result word with nothing expected: %h", d);
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      if (d[31:0] !== e.frame_us) begin
        $error("frame_us exp %0d got %0d", e.frame_us, d[31:0]); errors++;
      end
      if (d[63:32] !== e.avg_frame_us) begin
        $error("avg_frame_us exp %0d got %0d", e.avg_frame_us, d[63:32]); errors++;
      end
      if (d[95:64] !== e.frames_seen) begin
        $error("frames_seen exp %0d got %0d", e.frames_seen, d[95:64]); errors++;
      end
      if (d[115:96] !== e.current_fps) begin
        $error("current_fps exp %0d got %0d", e.current_fps, d[115:96]); errors++;
      end
      if (d[135:116] !== e.average_fps) begin
        $error("average_fps exp %0d got %0d", e.average_fps, d[135:116]); errors++;
      end
      if (d[167:136] !== e.pct_frame_us) begin
        $error("pct_frame_us exp %0d got %0d", e.pct_frame_us, d[167:136]); errors++;
      end
      if (d[188:168] !== e.sleep_us) begin
        $error("sleep_us exp %0d got %0d", e.sleep_us, d[188:168]); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  frame_stats_board board = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  frame_time_statistics_monitor uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: random stall bursts, none once quiet
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tdata);
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      stall_left <= $urandom_range(3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_frame(bit [31:0] start_us, bit [31:0] end_us, bit [6:0] pct);
    if (!quiet && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, pct, end_us, start_us};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_frame(start_us, end_us, pct);
  endtask

  task automatic send_len(bit [31:0] frame, bit [6:0] pct);
    bit [31:0] st;
    st = $urandom;
    send_frame(st, st + frame, pct);
  endtask

  // waits for every expected word, then lets any late frame drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (FrameCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(bit [31:0] en, bit [31:0] target, bit [31:0] mode);
    reg_idx_e  idx[3];
    bit [31:0] val[3];
    idx = '{RegEnable, RegTarget, RegMode};
    val = '{en, target, mode};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic bit [31:0] rand_frame();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(40000, 2000);
    if (k < 85) return $urandom_range(600);
    if (k < 95) return $urandom_range(2000000);
    return $urandom;
  endfunction

  function automatic bit [6:0] rand_pct();
    if ($urandom_range(9) == 0) return $urandom_range(127, 101);
    return $urandom_range(100);
  endfunction

  initial begin
    bit [31:0] tgt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero frame first so total time stays zero
    send_frame(32'h0, 32'h0, 7'd0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
    send_frame(32'hFFFF_FFF0, 32'h0000_1000, 7'd100);
    send_frame(32'h0, 32'hFFFF_FFFF, 7'd50);
    send_len(16000, 7'd101);
    send_len(16200, 7'd99);
    send_len(20000, 7'd1);
    send_len(5000, 7'h55);
    send_len(5000, 7'h2A);
    drain();
    // immediate mode, shortest target
    write_regs(1, 1, ModeImmediate);
    send_len(0, 7'd90);
    send_len(10, 7'd10);
    send_len(400000, 7'd100);
    drain();
    // half rate, longest target
    write_regs(1, 1000000, ModeHalfRate);
    send_len(0, 7'd0);
    send_len(1999000, 7'd30);
    send_len(2000000, 7'd70);
    drain();
    // adaptive, zero period
    write_regs(1, 0, 2'd3);
    send_len(0, 7'd60);
    send_len(5, 7'd60);
    drain();
    // disabled frames leave no trace
    write_regs(0, 16667, 0);
    send_len(1234, 7'd20);
    send_len(99999, 7'd80);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 2'd3;
    cfg_data_i <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    write_regs(1, 16667, 0);
    send_len(16667 - 501, 7'd40);
    send_len(16667 - 500, 7'd40);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: tgt = 1;
        1: tgt = 1000000;
        default: tgt = $urandom_range(40000, 4000);
      endcase
      write_regs(1, tgt, $urandom_range(3));
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 145; n++) send_len(rand_frame(), rand_pct());
      drain();
    end

    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
